### rtl/core/toeq_pkg.sv
// Package with the types and constants shared by the event queue modules.
package toeq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int STAMP_W = 32;
	localparam int ID_W = 10;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_POP = 2'd1,
		OP_REMOVE = 2'd2,
		OP_LOOKUP = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic [STAMP_W-1:0] stamp;
		logic [ID_W-1:0] id;
		logic pre;
		logic lvb;
		logic enb;
	} entry_t;

	typedef struct packed {
		logic act;
		op_t op;
		logic full;
		entry_t ent;
	} cmd_t;

	typedef struct packed {
		logic valid;
		entry_t ent;
		logic le;
		logic hit;
	} link_t;

endpackage

### rtl/core/toeq_cell.sv
// One slot of the sorted event chain, with its compare and shift logic.
module toeq_cell (
	input logic clk,
	input logic arst_n,
	input toeq_pkg::cmd_t cmd,
	input toeq_pkg::link_t left,
	input toeq_pkg::link_t right,
	output toeq_pkg::link_t link,
	output logic first
);
	import toeq_pkg::*;

	logic valid_q;
	entry_t ent_q;
	logic match;
	logic valid_d;
	entry_t ent_d;

	assign match = valid_q && (ent_q.id == cmd.ent.id);
	assign first = match && !left.hit;

	always_comb begin
		link.valid = valid_q;
		link.ent = ent_q;
		link.le = valid_q && (ent_q.stamp <= cmd.ent.stamp);
		link.hit = left.hit || match;
	end

	always_comb begin
		valid_d = valid_q;
		ent_d = ent_q;
		if (cmd.act) begin
			unique case (cmd.op)
				OP_INSERT: begin
					if (!cmd.full && !link.le) begin
						if (left.le) begin
							valid_d = 1'b1;
							ent_d = cmd.ent;
						end else begin
							valid_d = left.valid;
							ent_d = left.ent;
						end
					end
				end
				OP_POP: begin
					valid_d = right.valid;
					ent_d = right.ent;
				end
				OP_REMOVE: begin
					if (link.hit) begin
						valid_d = right.valid;
						ent_d = right.ent;
					end
				end
				OP_LOOKUP: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_d;
	end

endmodule

### rtl/core/timestamp_ordered_event_queue.sv
// Top level of the timestamp-ordered event queue built as a chain of sorted cells.
// An item is taken when start is high and busy is low; its result is on the ports for the
// single cycle that follows the next clock edge, marked by done, and the receiver cannot
// stall it. No item is taken while busy is high: the command is registered at acceptance
// and every cell of the chain compares, shifts and updates at the following edge. The
// queue holds up to 64 events sorted by timestamp, equal timestamps in arrival order.
module timestamp_ordered_event_queue (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] op,
	input logic [toeq_pkg::STAMP_W-1:0] stamp,
	input logic [toeq_pkg::ID_W-1:0] proc_id,
	input logic is_preempt,
	input logic leaves_blocked,
	input logic enters_blocked,
	output logic done,
	output logic [1:0] status,
	output logic [toeq_pkg::STAMP_W-1:0] got_stamp,
	output logic [toeq_pkg::ID_W-1:0] got_id,
	output logic got_preempt,
	output logic got_leaves_blocked,
	output logic got_enters_blocked,
	output logic head_valid,
	output logic [toeq_pkg::STAMP_W-1:0] head_stamp,
	output logic [toeq_pkg::CNT_W-1:0] occupancy,
	output logic [toeq_pkg::CNT_W-1:0] preempt_count,
	output logic [toeq_pkg::CNT_W-1:0] leave_blocked_count,
	output logic [toeq_pkg::CNT_W-1:0] enter_blocked_count
);
	import toeq_pkg::*;

	logic pend_q;
	op_t op_q;
	entry_t ent_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] pre_q;
	logic [CNT_W-1:0] lvb_q;
	logic [CNT_W-1:0] enb_q;
	logic done_q;
	status_t status_q;
	entry_t got_q;

	cmd_t cmd;
	link_t links [QUEUE_DEPTH];
	link_t lefts [QUEUE_DEPTH];
	link_t rights [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] firsts;
	entry_t sel;
	entry_t got_d;
	status_t status_d;
	logic full;
	logic found;
	logic take;

	assign full = (fill_q == CNT_W'(QUEUE_DEPTH));
	assign found = links[QUEUE_DEPTH-1].hit;

	always_comb begin
		cmd.act = pend_q;
		cmd.op = op_q;
		cmd.full = full;
		cmd.ent = ent_q;
	end

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (i == 0) begin
				lefts[i] = '0;
				lefts[i].le = 1'b1;
				lefts[i].valid = 1'b1;
			end else begin
				lefts[i] = links[i-1];
			end
			if (i == QUEUE_DEPTH - 1) begin
				rights[i] = '0;
			end else begin
				rights[i] = links[i+1];
			end
		end
	end

	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		toeq_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.cmd(cmd),
			.left(lefts[g]),
			.right(rights[g]),
			.link(links[g]),
			.first(firsts[g])
		);
	end

	always_comb begin
		sel = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			sel = sel | (links[i].ent & {$bits(entry_t){firsts[i]}});
		end
	end

	always_comb begin
		got_d = '0;
		status_d = ST_OK;
		take = 1'b0;
		unique case (op_q)
			OP_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end
			end
			OP_POP: begin
				if (fill_q == '0) begin
					status_d = ST_MISS;
				end else begin
					got_d = links[0].ent;
					take = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (!found) begin
					status_d = ST_MISS;
				end else begin
					got_d = sel;
					take = 1'b1;
				end
			end
			OP_LOOKUP: begin
				if (!found) begin
					status_d = ST_MISS;
				end else begin
					got_d = sel;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			done_q <= 1'b0;
			fill_q <= '0;
			pre_q <= '0;
			lvb_q <= '0;
			enb_q <= '0;
		end else begin
			pend_q <= start && !pend_q;
			done_q <= pend_q;
			if (pend_q) begin
				if (op_q == OP_INSERT && !full) begin
					fill_q <= fill_q + CNT_W'(1);
					pre_q <= pre_q + CNT_W'(ent_q.pre);
					lvb_q <= lvb_q + CNT_W'(ent_q.lvb);
					enb_q <= enb_q + CNT_W'(ent_q.enb);
				end else if (take) begin
					fill_q <= fill_q - CNT_W'(1);
					pre_q <= pre_q - CNT_W'(got_d.pre);
					lvb_q <= lvb_q - CNT_W'(got_d.lvb);
					enb_q <= enb_q - CNT_W'(got_d.enb);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !pend_q) begin
			op_q <= op_t'(op);
			ent_q.stamp <= stamp;
			ent_q.id <= proc_id;
			ent_q.pre <= is_preempt;
			ent_q.lvb <= leaves_blocked;
			ent_q.enb <= enters_blocked;
		end
		if (pend_q) begin
			status_q <= status_d;
			got_q <= got_d;
		end
	end

	assign busy = pend_q;
	assign done = done_q;
	assign status = status_q;
	assign got_stamp = got_q.stamp;
	assign got_id = got_q.id;
	assign got_preempt = got_q.pre;
	assign got_leaves_blocked = got_q.lvb;
	assign got_enters_blocked = got_q.enb;
	assign head_valid = links[0].valid;
	assign head_stamp = links[0].valid ? links[0].ent.stamp : '0;
	assign occupancy = fill_q;
	assign preempt_count = pre_q;
	assign leave_blocked_count = lvb_q;
	assign enter_blocked_count = enb_q;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |=> done_q)
		else $error("Accepted item produced no result.");

	a_head_matches_fill: assert property (@(posedge clk) disable iff (!arst_n)
		links[0].valid == (fill_q != '0))
		else $error("Head cell validity disagrees with the fill count.");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(QUEUE_DEPTH))
		else $error("Fill count exceeds the queue depth.");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == ST_FULL) |-> (fill_q == CNT_W'(QUEUE_DEPTH)))
		else $error("Insert dropped while the queue was not full.");

endmodule
